// File: design/assert_macros.svh
// assertion macros used by the checker file
// expects a signal named clock and a signal named reset in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LZW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock edge, reset included
`define LZW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/lzw_pkg.sv
// constants, codes and shared types of the lzw encoder
// no dependencies
package lzw_pkg;

   localparam int TABLE_ENTRIES = 35023;
   localparam int MAX_CODE_BITS = 15;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
   localparam int CODE_W        = 15;
   localparam int NFREE_W       = MAX_CODE_BITS + 1;

   localparam logic [CODE_W-1:0]  CODE_END   = CODE_W'(256);
   localparam logic [CODE_W-1:0]  CODE_BUMP  = CODE_W'(257);
   localparam logic [CODE_W-1:0]  CODE_FLUSH = CODE_W'(258);
   localparam logic [NFREE_W-1:0] CODE_FIRST = NFREE_W'(259);
   localparam logic [NFREE_W-1:0] CODE_LIMIT = NFREE_W'((1 << MAX_CODE_BITS) - 1);
   localparam logic [3:0]         WIDTH_INIT = 4'd9;
   localparam logic [CODE_W-1:0]  THR_INIT   = CODE_W'(511);
   localparam logic [ADDR_W-1:0]  TABLE_LAST = ADDR_W'(TABLE_ENTRIES - 1);
   localparam logic [ADDR_W:0]    SLOT_COUNT = (ADDR_W+1)'(TABLE_ENTRIES);

   // one dictionary slot
   typedef struct packed {
      logic              used;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] parent;
      logic [7:0]        data;
   } entry_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic clear_wr;
      logic probe_next;
      logic hit_take;
      logic store;
      logic code_used;
      logic emit_first;
      logic emit_second;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic prefix_valid;
      logic slot_used;
      logic slot_match;
      logic probe_last;
      logic clear_last;
      logic out_free;
      logic need_second;
      logic flush;
      logic end_item;
   } status_type;

endpackage

// File: design/lzw_if.sv
// valid/ready channel interfaces of the lzw encoder
// depends on lzw_pkg
interface lzw_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;
   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface lzw_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lzw_pkg::CODE_W-1:0] code;
   logic [3:0]                code_width;
   logic                      stream_done;
   logic                      last_of_run;
   modport source (output valid, output code, output code_width, output stream_done,
                   output last_of_run, input ready);
   modport sink   (input valid, input code, input code_width, input stream_done,
                   input last_of_run, output ready);
endinterface

// File: design/lzw_ctrl.sv
// controller state machine of the lzw encoder
// depends on lzw_pkg
module lzw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_ready,
   input  lzw_pkg::status_type status,
   output lzw_pkg::cmd_type    cmd
);
   import lzw_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_PROBE = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_OUT1  = 6'b010000,
      ST_OUT2  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_action)                state_in = ST_OUT1;
               else if (status.prefix_valid)  state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.slot_used) begin
               cmd.store     = 1'b1;
               cmd.code_used = 1'b1;
               state_in      = ST_OUT1;
            end else if (status.slot_match) begin
               cmd.hit_take = 1'b1;
               state_in     = ST_IDLE;
            end else if (status.probe_last) begin
               cmd.code_used = 1'b1;
               state_in      = ST_OUT1;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_PROBE;
            end
         end
         ST_OUT1: begin
            if (status.out_free) begin
               cmd.emit_first = 1'b1;
               state_in = (status.end_item || status.need_second) ? ST_OUT2 : ST_IDLE;
            end
         end
         ST_OUT2: begin
            if (status.out_free) begin
               cmd.emit_second = 1'b1;
               state_in = (status.end_item || status.flush) ? ST_CLEAR : ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

// File: design/lzw_dpath.sv
// datapath of the lzw encoder: dictionary memory, probe unit, code state, output register
// depends on lzw_pkg
module lzw_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  lzw_pkg::cmd_type           cmd,
   output lzw_pkg::status_type        status,
   input  logic                       in_action,
   input  logic [7:0]                 in_byte,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [lzw_pkg::CODE_W-1:0] out_code,
   output logic [3:0]                 out_width,
   output logic                       out_done,
   output logic                       out_last
);
   import lzw_pkg::*;

   entry_type          dict_mem [TABLE_ENTRIES];
   entry_type          rd_ff;
   logic [ADDR_W-1:0]  idx_ff, step_ff, cnt_ff, clr_addr_ff;
   logic               action_ff;
   logic [7:0]         byte_ff;
   logic [CODE_W-1:0]  prefix_ff;
   logic               pvalid_ff;
   logic [NFREE_W-1:0] nfree_ff;
   logic [3:0]         width_ff;
   logic [CODE_W-1:0]  thr_ff;
   logic               ovalid_ff;
   logic [CODE_W-1:0]  ocode_ff;
   logic [3:0]         owidth_ff;
   logic               odone_ff, olast_ff;

   logic [CODE_W-1:0]  hash_raw;
   logic [ADDR_W:0]    home_wide;
   logic [ADDR_W-1:0]  home, home_step, idx_next;
   logic               flush, need2;
   logic [CODE_W-1:0]  lead_code;

   // home slot and secondary step
   always_comb begin
      hash_raw  = {in_byte, {(CODE_W-8){1'b0}}} ^ prefix_ff;
      home_wide = (ADDR_W+1)'(hash_raw);
      if (home_wide >= SLOT_COUNT) home_wide = home_wide - SLOT_COUNT;
      home      = home_wide[ADDR_W-1:0];
      home_step = (home == '0) ? ADDR_W'(1) : ADDR_W'(SLOT_COUNT - (ADDR_W+1)'(home));
   end

   // next probe slot, wrapping around the table
   always_comb begin
      if (idx_ff >= step_ff) idx_next = idx_ff - step_ff;
      else idx_next = ADDR_W'((ADDR_W+1)'(idx_ff) + SLOT_COUNT - (ADDR_W+1)'(step_ff));
   end

   assign flush     = nfree_ff > CODE_LIMIT;
   assign need2     = flush || (nfree_ff > NFREE_W'(thr_ff));
   assign lead_code = (action_ff && !pvalid_ff) ? CODE_END : prefix_ff;

   // dictionary memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         dict_mem[clr_addr_ff] <= '0;
      end else if (cmd.store) begin
         dict_mem[idx_ff] <= '{used: 1'b1, code: nfree_ff[CODE_W-1:0],
                               parent: prefix_ff, data: byte_ff};
      end
      rd_ff <= dict_mem[idx_ff];
   end

   // probe position and clearing address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end else if (cmd.emit_second) begin
         clr_addr_ff <= '0;
      end
      if (cmd.accept) begin
         idx_ff  <= home;
         step_ff <= home_step;
         cnt_ff  <= '0;
      end else if (cmd.probe_next) begin
         idx_ff <= idx_next;
         cnt_ff <= cnt_ff + ADDR_W'(1);
      end
   end

   // item latch, prefix and code width state
   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         prefix_ff <= '0;
         nfree_ff  <= CODE_FIRST;
         width_ff  <= WIDTH_INIT;
         thr_ff    <= THR_INIT;
         action_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            action_ff <= in_action;
            byte_ff   <= in_byte;
            if (!in_action && !pvalid_ff) begin
               prefix_ff <= CODE_W'(in_byte);
               pvalid_ff <= 1'b1;
            end
         end
         if (cmd.hit_take) prefix_ff <= rd_ff.code;
         if (cmd.code_used) nfree_ff <= nfree_ff + NFREE_W'(1);
         if (cmd.emit_first && !action_ff) prefix_ff <= CODE_W'(byte_ff);
         if (cmd.emit_second) begin
            if (action_ff || flush) begin
               nfree_ff <= CODE_FIRST;
               width_ff <= WIDTH_INIT;
               thr_ff   <= THR_INIT;
               if (action_ff) begin
                  prefix_ff <= '0;
                  pvalid_ff <= 1'b0;
               end
            end else begin
               width_ff <= width_ff + 4'd1;
               thr_ff   <= {thr_ff[CODE_W-2:0], 1'b1};
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.emit_first || cmd.emit_second) begin
         ovalid_ff <= 1'b1;
      end else if (out_ready) begin
         ovalid_ff <= 1'b0;
      end
      if (cmd.emit_first) begin
         ocode_ff  <= lead_code;
         owidth_ff <= width_ff;
         odone_ff  <= 1'b0;
         olast_ff  <= !action_ff && !need2;
      end else if (cmd.emit_second) begin
         ocode_ff  <= action_ff ? CODE_END : (flush ? CODE_FLUSH : CODE_BUMP);
         owidth_ff <= width_ff;
         odone_ff  <= action_ff;
         olast_ff  <= 1'b1;
      end
   end

   assign out_valid = ovalid_ff;
   assign out_code  = ocode_ff;
   assign out_width = owidth_ff;
   assign out_done  = odone_ff;
   assign out_last  = olast_ff;

   // status to the controller
   always_comb begin
      status.prefix_valid = pvalid_ff;
      status.slot_used    = rd_ff.used;
      status.slot_match   = (rd_ff.parent == prefix_ff) && (rd_ff.data == byte_ff);
      status.probe_last   = (cnt_ff == TABLE_LAST);
      status.clear_last   = (clr_addr_ff == TABLE_LAST);
      status.out_free     = !ovalid_ff || out_ready;
      status.need_second  = need2;
      status.flush        = flush;
      status.end_item     = action_ff;
   end

endmodule

// File: design/lzw_variable_width_encoder.sv
// LZW encoder with 9 to 15 bit codes over a 35023-slot hashed dictionary.
// After reset, after each end-of-stream word and after each FLUSH code the
// dictionary memory is cleared one slot per cycle, during which no input word
// is taken. A data word that starts a new string passes through accept,
// memory read, compare and result load when the first probe settles it; a
// known string ends after the compare, and a BUMP or FLUSH code adds a second
// result load. Every further probe repeats the memory read and compare. The
// first byte of a stream is only latched as the prefix, and the controller
// stays idle. The registered read of the dictionary memory puts a read step
// before each compare. A result sits in an output register, so the next word
// is taken while it waits. An end-of-stream word gives two results, the
// prefix (or END on an empty stream) and END with stream_done set.
// depends on lzw_pkg, lzw_if, lzw_ctrl, lzw_dpath
module lzw_variable_width_encoder (
   input logic       clock,
   input logic       reset,
   lzw_req_if.sink   req_chan,
   lzw_rsp_if.source rsp_chan
);
   import lzw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller
   lzw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   lzw_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_action (req_chan.action),
      .in_byte   (req_chan.data_byte),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_code  (rsp_chan.code),
      .out_width (rsp_chan.code_width),
      .out_done  (rsp_chan.stream_done),
      .out_last  (rsp_chan.last_of_run)
   );

endmodule

// File: design/lzw_checker.sv
// port-level checks of the lzw encoder, bound to the top level
// depends on lzw_pkg and assert_macros.svh
`include "assert_macros.svh"

module lzw_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [lzw_pkg::CODE_W-1:0] rsp_code,
   input logic [3:0]                 rsp_width,
   input logic                       rsp_done,
   input logic                       rsp_last
);
   import lzw_pkg::*;

   // clearing pass follows reset, so no word is taken right after it
   `LZW_ASSERT_ALWAYS(a_clear_after_reset, reset |=> !req_ready, "word taken during clearing")

   // a stalled result word holds
   `LZW_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code), "result changed while stalled")

   // stream end is an END code closing its run
   `LZW_ASSERT(a_done_end, rsp_valid && rsp_done |-> rsp_code == CODE_END && rsp_last, "bad stream end")

   // code width stays within 9 to 15 bits
   `LZW_ASSERT(a_width_range, rsp_valid |-> rsp_width >= 4'd9 && rsp_width <= 4'd15, "code width out of range")

endmodule

bind lzw_variable_width_encoder lzw_checker u_lzw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_code  (rsp_chan.code),
   .rsp_width (rsp_chan.code_width),
   .rsp_done  (rsp_chan.stream_done),
   .rsp_last  (rsp_chan.last_of_run)
);

// File: dv/tb_lzw_variable_width_encoder.sv
// testbench for the lzw variable width encoder: random and directed byte streams,
// results checked against an in-bench dictionary predictor
// depends on lzw_pkg, lzw_if and the encoder rtl
`timescale 1ns / 100ps

module tb_lzw_variable_width_encoder;
   import lzw_pkg::*;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   typedef struct {
      logic       action;
      logic [7:0] data_byte;
      bit         drain_first;
   } stim_word_type;

   typedef struct {
      logic [CODE_W-1:0] code;
      logic [3:0]        code_width;
      logic              stream_done;
      logic              last_of_run;
   } code_word_type;

   logic clock;
   logic reset;

   lzw_req_if req_bus ();
   lzw_rsp_if rsp_bus ();

   lzw_variable_width_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // stimulus and expected code words
   stim_word_type pending_words[$];
   code_word_type expected_codes[$];

   // predictor state: hashed dictionary plus prefix and width tracking
   bit                dict_used   [TABLE_ENTRIES];
   logic [CODE_W-1:0] dict_code   [TABLE_ENTRIES];
   logic [CODE_W-1:0] dict_parent [TABLE_ENTRIES];
   logic [7:0]        dict_byte   [TABLE_ENTRIES];
   int unsigned       cur_prefix;
   bit                have_prefix;
   int unsigned       free_code;
   int unsigned       cur_width;
   int unsigned       widen_limit;

   int n_sent, n_checked, n_errors;
   int n_bumps, n_flushes, n_streams;
   bit hold_done;
   int hold_left;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void dict_restart();
      foreach (dict_used[i]) dict_used[i] = 1'b0;
      free_code   = CODE_FIRST;
      cur_width   = WIDTH_INIT;
      widen_limit = THR_INIT;
   endfunction

   function automatic void push_code(int unsigned code, bit done, bit last);
      code_word_type w;
      w.code        = code[CODE_W-1:0];
      w.code_width  = cur_width[3:0];
      w.stream_done = done;
      w.last_of_run = last;
      expected_codes.push_back(w);
   endfunction

   // expected code words for one accepted input word
   function automatic void lzw_predict(logic action, logic [7:0] b);
      int unsigned idx, step, n;
      bit found;
      if (action == ACT_END) begin
         push_code(have_prefix ? cur_prefix : int'(CODE_END), 1'b0, 1'b0);
         push_code(CODE_END, 1'b1, 1'b1);
         dict_restart();
         cur_prefix  = 0;
         have_prefix = 1'b0;
         return;
      end
      if (!have_prefix) begin
         cur_prefix  = b;
         have_prefix = 1'b1;
         return;
      end
      // open addressing with a subtractive secondary step
      idx = ((int'(b) << (MAX_CODE_BITS - 8)) ^ cur_prefix) % TABLE_ENTRIES;
      step = (idx == 0) ? 1 : TABLE_ENTRIES - idx;
      found = 1'b0;
      for (n = 0; n < TABLE_ENTRIES; n++) begin
         if (!dict_used[idx] || (dict_parent[idx] == cur_prefix && dict_byte[idx] == b)) begin
            found = 1'b1;
            break;
         end
         idx = (idx >= step) ? idx - step : idx + TABLE_ENTRIES - step;
      end
      if (found && dict_used[idx]) begin
         cur_prefix = dict_code[idx];
         return;
      end
      if (found) begin
         dict_used[idx]   = 1'b1;
         dict_code[idx]   = free_code[CODE_W-1:0];
         dict_parent[idx] = cur_prefix[CODE_W-1:0];
         dict_byte[idx]   = b;
      end
      free_code++;
      if (free_code > CODE_LIMIT) begin
         push_code(cur_prefix, 1'b0, 1'b0);
         push_code(CODE_FLUSH, 1'b0, 1'b1);
         dict_restart();
      end else if (free_code > widen_limit) begin
         push_code(cur_prefix, 1'b0, 1'b0);
         push_code(CODE_BUMP, 1'b0, 1'b1);
         cur_width++;
         widen_limit = (widen_limit << 1) | 1;
      end else begin
         push_code(cur_prefix, 1'b0, 1'b1);
      end
      cur_prefix = b;
   endfunction

   function automatic int sender_idle_pct();
      if (n_sent < 400) return 36;
      if (n_sent < 800) return 87;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (n_sent < 400) return 87;
      if (n_sent < 800) return 36;
      return 0;
   endfunction

   // driver: offers queued words, predicts each one on acceptance
   always @(posedge clock) begin : word_driver
      bit taken;
      stim_word_type w;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.action    <= 1'b0;
         req_bus.data_byte <= 8'd0;
      end else begin
         taken = req_bus.valid && req_bus.ready;
         if (taken) begin
            lzw_predict(req_bus.action, req_bus.data_byte);
            n_sent++;
         end
         if (!req_bus.valid || taken) begin
            if (pending_words.size() > 0
                && !(pending_words[0].drain_first && expected_codes.size() > 0)
                && $urandom_range(99) >= sender_idle_pct()) begin
               w = pending_words.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.action    <= w.action;
               req_bus.data_byte <= w.data_byte;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         hold_done     <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!hold_done && n_checked >= 40) begin
         rsp_bus.ready <= 1'b0;
         hold_done     <= 1'b1;
         hold_left     <= 400;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // monitor: compare each code word with the oldest expectation
   always @(posedge clock) begin : code_monitor
      code_word_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_codes.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
               $display("unexpected word: code %0d width %0d done %0b last %0b",
                        rsp_bus.code, rsp_bus.code_width, rsp_bus.stream_done,
                        rsp_bus.last_of_run);
         end else begin
            e = expected_codes.pop_front();
            if (rsp_bus.code !== e.code || rsp_bus.code_width !== e.code_width
                || rsp_bus.stream_done !== e.stream_done
                || rsp_bus.last_of_run !== e.last_of_run) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("word %0d: exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                           n_checked, e.code, e.code_width, e.stream_done, e.last_of_run,
                           rsp_bus.code, rsp_bus.code_width, rsp_bus.stream_done,
                           rsp_bus.last_of_run);
            end
            if (e.code == CODE_BUMP && e.last_of_run && !e.stream_done) n_bumps++;
            if (e.code == CODE_FLUSH && e.last_of_run) n_flushes++;
            if (e.stream_done) n_streams++;
         end
         n_checked++;
      end
   end

   task automatic queue_byte(logic [7:0] b, bit drain = 1'b0);
      stim_word_type w;
      w.action      = ACT_BYTE;
      w.data_byte   = b;
      w.drain_first = drain;
      pending_words.push_back(w);
   endtask

   task automatic queue_end(bit drain = 1'b0);
      stim_word_type w;
      w.action      = ACT_END;
      w.data_byte   = 8'($urandom);
      w.drain_first = drain;
      pending_words.push_back(w);
   endtask

   // stimulus
   initial begin : stimulus
      int len, alpha, x, k;
      n_sent = 0; n_checked = 0; n_errors = 0;
      n_bumps = 0; n_flushes = 0; n_streams = 0;
      cur_prefix = 0;
      have_prefix = 1'b0;
      dict_restart();

      // empty stream, then byte extremes with repeated strings
      queue_end();
      queue_byte(8'd0, 1'b1);
      queue_byte(8'd255);
      queue_byte(8'd0);
      queue_byte(8'd255);
      queue_byte(8'd0);
      queue_byte(8'd255);
      queue_byte(8'd255);
      queue_byte(8'd255);
      queue_byte(8'hAA);
      queue_byte(8'h55);
      queue_end();
      // single byte stream
      queue_byte(8'h80, 1'b1);
      queue_end();

      // random streams, mostly full range bytes, one over a small alphabet
      for (int st = 0; st < 3; st++) begin
         len   = (st == 2) ? 350 : $urandom_range(220, 300);
         alpha = (st == 1) ? 3 : 255;
         for (int i = 0; i < len; i++)
            queue_byte(8'($urandom_range(alpha)), i == 0 && st == 2);
         queue_end();
      end

      // stream of novel byte pairs that pushes the code width up
      x = $urandom_range(255);
      for (k = 0; k < 256; k++) begin
         queue_byte(8'(x), k == 0);
         x = (x + 1) & 8'hFF;
      end
      queue_end();

      wait (pending_words.size() == 0 && !req_bus.valid);
      wait (expected_codes.size() == 0);
      repeat (100) @(posedge clock);
      $display("sent %0d input words, checked %0d codes over %0d streams", n_sent,
               n_checked, n_streams);
      $display("width increases %0d, dictionary flushes %0d", n_bumps, n_flushes);
      if (n_errors == 0 && expected_codes.size() == 0)
         $display("lzw_variable_width_encoder: match");
      else
         $display("lzw_variable_width_encoder: mismatch");
      $finish;
   end

   // watchdog
   initial begin
      #36_000_000;
      $display("lzw_variable_width_encoder: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/lzw_pkg.sv
design/lzw_if.sv
design/lzw_ctrl.sv
design/lzw_dpath.sv
design/lzw_variable_width_encoder.sv
design/lzw_checker.sv
dv/tb_lzw_variable_width_encoder.sv
